[rtl/nll_pkg.sv]
// nll_pkg: shared constants, types and helpers of the nonlinear ladder lowpass
// holds the tanh lookup table built at elaboration; no dependencies
package nll_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int STATE_BITS   = 24;
   localparam int TANH_ENTRIES = 1024;
   localparam int FRAC         = STATE_BITS - 4;
   localparam int LOG2N        = $clog2(TANH_ENTRIES);
   localparam int XS_SHIFT     = FRAC - (SAMPLE_BITS - 1);
   localparam int INV_TWO_VT   = 1680410;

   localparam int GAIN_BITS = 20;
   localparam int REG_BITS  = 16;
   localparam int WDATA_BITS = 20;

   localparam logic [19:0] GAIN_RESET      = 20'd46547;
   localparam logic [15:0] RESONANCE_RESET = 16'd1638;
   localparam logic [15:0] DRIVE_RESET     = 16'd256;
   localparam logic [15:0] WET_RESET       = 16'd32768;
   localparam logic [15:0] WET_FULL        = 16'd32768;

   localparam logic [1:0] REG_STAGE_GAIN = 2'd0;
   localparam logic [1:0] REG_RESONANCE  = 2'd1;
   localparam logic [1:0] REG_DRIVE      = 2'd2;
   localparam logic [1:0] REG_WET_MIX    = 2'd3;

   typedef logic signed [STATE_BITS-1:0] state_type;
   typedef state_type tanh_rom_type [TANH_ENTRIES];

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_IN_DRV,
      OP_IN_RES,
      OP_IN_SUM,
      OP_TH_MUL,
      OP_TH_IDX,
      OP_TH_RD,
      OP_TH_MUL2,
      OP_TH_FIN,
      OP_ST_MUL,
      OP_ST_INT,
      OP_OUT_MUL,
      OP_OUT_FIN
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] k;
      logic       to_stage;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // round half up, then floor shift
   function automatic logic signed [47:0] rnd48(input logic signed [47:0] v, input int n);
      logic signed [47:0] half;
      half = 48'sd1 <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   function automatic state_type sat_state(input logic signed [47:0] v);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = (48'sd1 <<< (STATE_BITS - 1)) - 48'sd1;
      lo = -(48'sd1 <<< (STATE_BITS - 1));
      if (v > hi) return hi[STATE_BITS-1:0];
      else if (v < lo) return lo[STATE_BITS-1:0];
      else return v[STATE_BITS-1:0];
   endfunction

   // shift and subtract quotient, used only while building the table
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned dvs);
      longint unsigned q;
      logic [64:0]     rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, dvs}) begin
            rem  = rem - {1'b0, dvs};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // tanh(4*i/N) in Q.FRAC, built from a Q31 series for e^(-8/N)
   function automatic tanh_rom_type build_tanh();
      tanh_rom_type t;
      longint unsigned one;
      longint unsigned y;
      longint unsigned term;
      longint unsigned r;
      longint unsigned e;
      longint unsigned den;
      longint unsigned t31;
      longint signed   tr;
      one  = 64'd1 << 31;
      y    = (64'd8 << 31) >> LOG2N;
      term = one;
      r    = one;
      e    = one;
      for (int k = 1; k <= 12; k++) begin
         term = udiv64(term * y, 64'(k) << 31);
         if (k[0]) r = r - term;
         else r = r + term;
      end
      for (int i = 0; i < TANH_ENTRIES; i++) begin
         den = one + e;
         t31 = udiv64(((one - e) << 31) + (den >> 1), den);
         if (FRAC <= 31) begin
            tr = (longint'(t31) + (64'sd1 <<< (31 - FRAC - 1))) >>> (31 - FRAC);
         end else begin
            tr = longint'(t31 << (FRAC - 31));
         end
         t[i] = tr[STATE_BITS-1:0];
         e = (e * r + (64'd1 << 30)) >> 31;
      end
      return t;
   endfunction

   localparam tanh_rom_type TANH_ROM = build_tanh();

endpackage

[rtl/nll_ctrl.sv]
// nll_ctrl: sequencer that steps the shared datapath through one sample
// depends on nll_pkg
module nll_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  nll_pkg::status_type status,
   output nll_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {S_IDLE, S_IN, S_TH, S_ST, S_OUT} fsm_type;

   fsm_type    state_ff;
   logic [2:0] sub_ff;
   logic [1:0] k_ff;
   logic       to_stage_ff;

   always_comb begin
      cmd.k        = k_ff;
      cmd.to_stage = to_stage_ff;
      cmd.op       = nll_pkg::OP_NOP;
      case (state_ff)
         S_IDLE: cmd.op = req_valid ? nll_pkg::OP_LOAD : nll_pkg::OP_NOP;
         S_IN: begin
            case (sub_ff)
               3'd0:    cmd.op = nll_pkg::OP_IN_DRV;
               3'd1:    cmd.op = nll_pkg::OP_IN_RES;
               default: cmd.op = nll_pkg::OP_IN_SUM;
            endcase
         end
         S_TH: begin
            case (sub_ff)
               3'd0:    cmd.op = nll_pkg::OP_TH_MUL;
               3'd1:    cmd.op = nll_pkg::OP_TH_IDX;
               3'd2:    cmd.op = nll_pkg::OP_TH_RD;
               3'd3:    cmd.op = nll_pkg::OP_TH_MUL2;
               default: cmd.op = nll_pkg::OP_TH_FIN;
            endcase
         end
         S_ST: cmd.op = (sub_ff == 3'd0) ? nll_pkg::OP_ST_MUL : nll_pkg::OP_ST_INT;
         S_OUT: begin
            if (sub_ff == 3'd0) cmd.op = nll_pkg::OP_OUT_MUL;
            else if (status.out_free) cmd.op = nll_pkg::OP_OUT_FIN;
            else cmd.op = nll_pkg::OP_NOP;
         end
         default: cmd.op = nll_pkg::OP_NOP;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         sub_ff      <= '0;
         k_ff        <= '0;
         to_stage_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_IN;
                  sub_ff   <= '0;
               end
            end
            S_IN: begin
               if (sub_ff == 3'd2) begin
                  state_ff    <= S_TH;
                  sub_ff      <= '0;
                  to_stage_ff <= 1'b0;
               end else begin
                  sub_ff <= sub_ff + 3'd1;
               end
            end
            S_TH: begin
               if (sub_ff == 3'd4) begin
                  sub_ff <= '0;
                  if (!to_stage_ff) begin
                     state_ff <= S_ST;
                     k_ff     <= '0;
                  end else if (k_ff == 2'd3) begin
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_ST;
                     k_ff     <= k_ff + 2'd1;
                  end
               end else begin
                  sub_ff <= sub_ff + 3'd1;
               end
            end
            S_ST: begin
               if (sub_ff == 3'd1) begin
                  state_ff    <= S_TH;
                  sub_ff      <= '0;
                  to_stage_ff <= 1'b1;
               end else begin
                  sub_ff <= sub_ff + 3'd1;
               end
            end
            S_OUT: begin
               if (sub_ff == 3'd0) begin
                  sub_ff <= 3'd1;
               end else if (status.out_free) begin
                  state_ff <= S_IDLE;
                  sub_ff   <= '0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/nll_datapath.sv]
// nll_datapath: filter state, settings, shared multiplier and tanh lookup
// depends on nll_pkg
module nll_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  nll_pkg::cmd_type                    cmd,
   output nll_pkg::status_type                 status,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [nll_pkg::WDATA_BITS-1:0]      csr_wdata,
   input  logic signed [nll_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic                                req_block_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [nll_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                rsp_block_end_out
);

   localparam int SB = nll_pkg::STATE_BITS;
   localparam int SMB = nll_pkg::SAMPLE_BITS;
   localparam int FR = nll_pkg::FRAC;
   localparam int NE = nll_pkg::TANH_ENTRIES;
   localparam int LN = nll_pkg::LOG2N;
   localparam int MAGW = FR + 3;
   localparam int POSW = MAGW + LN;

   logic [19:0] gain_ff;
   logic [15:0] res_ff, drive_ff, wet_ff;

   nll_pkg::state_type v_ff [4];
   nll_pkg::state_type s_ff [4];
   nll_pkg::state_type t_ff [4];
   nll_pkg::state_type tin_ff;

   logic signed [24:0] xs_ff;
   logic               be_ff;
   logic signed [31:0] acc_ff;
   logic signed [47:0] prod_ff;
   logic               neg_ff;
   logic [MAGW-1:0]    mag_ff;
   nll_pkg::state_type lo_ff;
   logic signed [24:0] diff_ff;
   logic [15:0]        frac_ff;

   logic signed [SMB-1:0] rsp_sample_ff;
   logic                  rsp_be_ff;
   logic                  rsp_valid_ff;

   logic signed [24:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [46:0] mul_p;
   logic [15:0]        wet_eff;

   // tanh intermediate values
   logic signed [47:0] lim8, th_r, th_c, lim4;
   logic [POSW-1:0]    pos;
   logic [POSW-FR-3:0] idx;
   logic               last;
   logic [LN-1:0]      idxc;
   nll_pkg::state_type th_res, th_val;
   logic signed [47:0] acc_clamp;

   // stage and output intermediate values
   nll_pkg::state_type slope, vnew;
   logic signed [47:0] vsum, y1, y2;
   logic signed [47:0] ylim;

   assign wet_eff = (wet_ff > nll_pkg::WET_FULL) ? nll_pkg::WET_FULL : wet_ff;
   assign mul_p   = mul_a * mul_b;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      lim8 = 48'sd8 <<< FR;
      lim4 = 48'sd4 <<< FR;
      acc_clamp = 48'(acc_ff);
      if (acc_clamp > lim8) acc_clamp = lim8;
      else if (acc_clamp < -lim8) acc_clamp = -lim8;
      th_r = nll_pkg::rnd48(prod_ff, 20);
      th_c = th_r;
      if (th_c > lim4) th_c = lim4;
      else if (th_c < -lim4) th_c = -lim4;
      pos  = {mag_ff, {LN{1'b0}}};
      idx  = pos[POSW-1:FR+2];
      last = (idx >= (POSW-FR-2)'(NE - 1));
      idxc = last ? LN'(NE - 2) : idx[LN-1:0];
      th_res = lo_ff + SB'(nll_pkg::rnd48(prod_ff, 16));
      th_val = neg_ff ? -th_res : th_res;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         nll_pkg::OP_IN_DRV: begin
            mul_a = xs_ff;
            mul_b = 22'($unsigned(drive_ff));
         end
         nll_pkg::OP_IN_RES: begin
            mul_a = 25'(v_ff[3]);
            mul_b = 22'($unsigned(res_ff));
         end
         nll_pkg::OP_TH_MUL: begin
            mul_a = acc_clamp[24:0];
            mul_b = 22'(nll_pkg::INV_TWO_VT);
         end
         nll_pkg::OP_TH_MUL2: begin
            mul_a = diff_ff;
            mul_b = 22'($unsigned(frac_ff));
         end
         nll_pkg::OP_ST_MUL: begin
            if (cmd.k == 2'd0) mul_a = -(25'(tin_ff) + 25'(t_ff[0]));
            else mul_a = 25'(t_ff[cmd.k - 2'd1]) - 25'(t_ff[cmd.k]);
            mul_b = 22'($unsigned(gain_ff));
         end
         nll_pkg::OP_OUT_MUL: begin
            mul_a = 25'(v_ff[3]) - xs_ff;
            mul_b = 22'($unsigned(wet_eff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      slope = nll_pkg::sat_state(nll_pkg::rnd48(prod_ff, 20));
      vsum  = 48'(v_ff[cmd.k]) + 48'(slope) + 48'(s_ff[cmd.k]);
      vnew  = nll_pkg::sat_state(vsum);
      y1    = 48'(xs_ff) + nll_pkg::rnd48(prod_ff, 15);
      y2    = nll_pkg::rnd48(y1, nll_pkg::XS_SHIFT);
      ylim  = 48'sd1 <<< (nll_pkg::SAMPLE_BITS - 1);
      if (y2 > ylim - 48'sd1) y2 = ylim - 48'sd1;
      else if (y2 < -ylim) y2 = -ylim;
   end

   // settings and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= nll_pkg::GAIN_RESET;
         res_ff   <= nll_pkg::RESONANCE_RESET;
         drive_ff <= nll_pkg::DRIVE_RESET;
         wet_ff   <= nll_pkg::WET_RESET;
         for (int i = 0; i < 4; i++) begin
            v_ff[i] <= '0;
            s_ff[i] <= '0;
            t_ff[i] <= '0;
         end
         tin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               nll_pkg::REG_STAGE_GAIN: gain_ff  <= csr_wdata[19:0];
               nll_pkg::REG_RESONANCE:  res_ff   <= csr_wdata[15:0];
               nll_pkg::REG_DRIVE:      drive_ff <= csr_wdata[15:0];
               nll_pkg::REG_WET_MIX:    wet_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.op == nll_pkg::OP_ST_INT) begin
            v_ff[cmd.k] <= vnew;
            s_ff[cmd.k] <= slope;
         end
         if (cmd.op == nll_pkg::OP_TH_FIN) begin
            if (cmd.to_stage) t_ff[cmd.k] <= th_val;
            else tin_ff <= th_val;
         end
         if (cmd.op == nll_pkg::OP_OUT_FIN) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      // product holds while the mix step waits for the output register
      if (cmd.op != nll_pkg::OP_NOP) prod_ff <= 48'(mul_p);
      case (cmd.op)
         nll_pkg::OP_LOAD: begin
            xs_ff <= 25'(req_sample_in) <<< nll_pkg::XS_SHIFT;
            be_ff <= req_block_end;
         end
         nll_pkg::OP_IN_RES: acc_ff <= 32'(nll_pkg::rnd48(prod_ff, 8));
         nll_pkg::OP_IN_SUM: acc_ff <= acc_ff + 32'(nll_pkg::rnd48(prod_ff, 14));
         nll_pkg::OP_TH_IDX: begin
            neg_ff <= th_c < 0;
            mag_ff <= (th_c < 0) ? MAGW'(-th_c) : MAGW'(th_c);
         end
         nll_pkg::OP_TH_RD: begin
            frac_ff <= pos[FR+1 -: 16];
            if (last) begin
               lo_ff   <= nll_pkg::TANH_ROM[NE-1];
               diff_ff <= '0;
            end else begin
               lo_ff   <= nll_pkg::TANH_ROM[idxc];
               diff_ff <= 25'(nll_pkg::TANH_ROM[idxc + LN'(1)]) -
                          25'(nll_pkg::TANH_ROM[idxc]);
            end
         end
         nll_pkg::OP_ST_INT: acc_ff <= 32'(vnew);
         nll_pkg::OP_OUT_FIN: begin
            rsp_sample_ff <= SMB'(y2);
            rsp_be_ff     <= be_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_block_end_out = rsp_be_ff;

endmodule

[rtl/nonlinear_ladder_lowpass.sv]
// nonlinear_ladder_lowpass: top level of the four-pole nonlinear ladder lowpass
// depends on nll_pkg, nll_ctrl and nll_datapath
//
// one signed sample in, one mixed sample out. each item passes through the
// accepting (load) cycle, the driven input and feedback sum, five tanh
// lookups (input plus four stage outputs), a slope and a trapezoid update
// step per stage, and a multiply and a finish step for the wet/dry mix. the
// finish step loads the output register and sets the sequencer idle, so the
// next item can be taken while that result is shown. all products go through
// one shared 25x22 multiplier, so one item is taken at a time. req_stall is
// high while an item is in flight; the next item is taken as soon as the
// sequence ends even if rsp_stall holds the previous result in the output
// register. if that result is still held when the next item reaches its mix
// step, the sequence waits there until the output register frees. settings
// must be written by the user only while idle (not enforced). no clearing pass.
module nonlinear_ladder_lowpass (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [nll_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic                                   req_block_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [nll_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                   rsp_block_end_out,
   input  logic                                   csr_we,
   input  logic [1:0]                             csr_index,
   input  logic [nll_pkg::WDATA_BITS-1:0]         csr_wdata
);

   nll_pkg::cmd_type    cmd;
   nll_pkg::status_type status;

   // sequencer
   nll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // state, settings, multiplier and tanh table
   nll_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_sample_in     (req_sample_in),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_block_end_out (rsp_block_end_out)
   );

endmodule

[rtl/nll_checker.sv]
// nll_checker: port-level checks of the ladder lowpass, bound to the top level
// depends on nll_pkg
module nll_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [nll_pkg::SAMPLE_BITS-1:0] rsp_sample_out
);

   // an accepted item keeps the input side busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not busy after item");

   // a new result appears only as the sequence ends
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result while busy");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed");

endmodule

bind nonlinear_ladder_lowpass nll_checker u_nll_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

[tb/sv/tb_nonlinear_ladder_lowpass.sv]
// tb_nonlinear_ladder_lowpass: self-checking testbench of the four-pole nonlinear ladder lowpass
// depends on nll_pkg and nonlinear_ladder_lowpass; carries its own bit-exact filter model
module tb_nonlinear_ladder_lowpass;
   timeunit 1ns;
   timeprecision 1ps;
   import nll_pkg::*;

   localparam int WATCHDOG_CYCLES = 3000;
   localparam int LONG_HOLD       = 400;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 110;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in;
   logic                          req_block_end;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_block_end_out;
   logic                          csr_we;
   logic [1:0]                    csr_index;
   logic [WDATA_BITS-1:0]         csr_wdata;

   nonlinear_ladder_lowpass dut (.*);

   // one expected output sample
   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          block_end;
   } filt_out_t;

   // directed row: either a register write or an item, optionally with a hand-typed result
   typedef struct {
      bit                            is_write;
      logic [1:0]                    reg_idx;
      logic [WDATA_BITS-1:0]         reg_val;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          block_end;
      bit                            typed;
      logic signed [SAMPLE_BITS-1:0] typed_out;
   } row_t;

   filt_out_t pending_out[$];
   int        mismatches = 0;
   int        idle_cycles = 0;
   bit        quiet = 0;        // no idling at all on either side
   int        hold_left = 0;    // long receiver hold-off
   int        stall_left = 0;

   // ---------------------------------------------------------------
   // filter model state, kept at full integer precision
   // ---------------------------------------------------------------
   longint lut[TANH_ENTRIES];
   longint volt[4];
   longint slope[4];
   longint vtanh[4];
   longint m_gain, m_res, m_drive, m_wet;

   function automatic longint rsh(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint state_sat(longint v);
      return clip(v, -(64'sd1 <<< (STATE_BITS - 1)), (64'sd1 <<< (STATE_BITS - 1)) - 1);
   endfunction

   // tanh ROM from a Q31 series of e^(-8/N), then (1-e)/(1+e)
   task automatic fill_lut();
      longint unsigned q31, step, term, ratio, ex, den, t31;
      q31   = 64'd1 << 31;
      step  = (64'd8 << 31) / TANH_ENTRIES;
      term  = q31;
      ratio = q31;
      ex    = q31;
      for (int k = 1; k <= 12; k++) begin
         term = (term * step) / (64'(k) << 31);
         if (k % 2) ratio -= term;
         else ratio += term;
      end
      for (int i = 0; i < TANH_ENTRIES; i++) begin
         den    = q31 + ex;
         t31    = (((q31 - ex) << 31) + den / 2) / den;
         lut[i] = rsh(longint'(t31), 31 - FRAC);
         ex     = (ex * ratio + (64'd1 << 30)) >> 31;
      end
   endtask

   // tanh(v / 2vt) with clamping, odd symmetry and linear interpolation
   function automatic longint soft_clip(longint v);
      longint arg, mag, pos, idx, frac16, res;
      arg = rsh(clip(v, -(64'sd8 <<< FRAC), 64'sd8 <<< FRAC) * INV_TWO_VT, 20);
      arg = clip(arg, -(64'sd4 <<< FRAC), 64'sd4 <<< FRAC);
      mag = (arg < 0) ? -arg : arg;
      pos = mag * TANH_ENTRIES;
      idx = pos >>> (FRAC + 2);
      if (idx >= TANH_ENTRIES - 1) begin
         res = lut[TANH_ENTRIES-1];
      end else begin
         frac16 = (pos >>> (FRAC + 2 - 16)) & 64'hFFFF;
         res = lut[idx] + rsh((lut[idx+1] - lut[idx]) * frac16, 16);
      end
      return (arg < 0) ? -res : res;
   endfunction

   task automatic stage_update(int k, longint s);
      s        = state_sat(s);
      volt[k]  = state_sat(volt[k] + s + slope[k]);
      slope[k] = s;
      vtanh[k] = soft_clip(volt[k]);
   endtask

   // advance the ladder by one sample and return the mixed output
   task automatic ladder_step(input logic signed [SAMPLE_BITS-1:0] x,
                              output logic signed [SAMPLE_BITS-1:0] y_out);
      longint xs, u, tin, y, wet;
      wet = (m_wet > 32768) ? 32768 : m_wet;
      xs  = longint'(x) <<< XS_SHIFT;
      u   = rsh(xs * m_drive, 8) + rsh(volt[3] * m_res, 14);
      tin = soft_clip(u);
      stage_update(0, rsh(-m_gain * (tin + vtanh[0]), 20));
      for (int k = 1; k < 4; k++)
         stage_update(k, rsh(m_gain * (vtanh[k-1] - vtanh[k]), 20));
      y = xs + rsh((volt[3] - xs) * wet, 15);
      y = clip(rsh(y, XS_SHIFT), -32768, 32767);
      y_out = y[SAMPLE_BITS-1:0];
   endtask

   // ---------------------------------------------------------------
   // clock and reset
   // ---------------------------------------------------------------
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset         <= 1;
      req_valid     <= 0;
      req_sample_in <= '0;
      req_block_end <= 0;
      csr_we        <= 0;
      csr_index     <= REG_STAGE_GAIN;
      csr_wdata     <= '0;
      repeat (7) @(posedge clock);
      reset <= 0;
   end

   // ---------------------------------------------------------------
   // receiver: random stall bursts, one long hold-off on request
   // ---------------------------------------------------------------
   initial begin
      rsp_stall <= 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
         end
      end
   end

   // ---------------------------------------------------------------
   // result checker: compare against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      filt_out_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: sample %0d block_end %0b",
                        rsp_sample_out, rsp_block_end_out);
         end else begin
            want = pending_out.pop_front();
            if (rsp_sample_out !== want.sample || rsp_block_end_out !== want.block_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: sample exp %0d got %0d, block_end exp %0b got %0b",
                           want.sample, rsp_sample_out, want.block_end, rsp_block_end_out);
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------
   // wait for every result, then let the block settle before a write
   task automatic drain();
      while (pending_out.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   // one write cycle followed by one quiet cycle on the register port
   task automatic write_reg(logic [1:0] idx, logic [WDATA_BITS-1:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_STAGE_GAIN: m_gain  = val[GAIN_BITS-1:0];
         REG_RESONANCE:  m_res   = val[REG_BITS-1:0];
         REG_DRIVE:      m_drive = val[REG_BITS-1:0];
         REG_WET_MIX:    m_wet   = val[REG_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // offer one item, model it once accepted
   task automatic send_item(logic signed [SAMPLE_BITS-1:0] x, logic be,
                            bit typed, logic signed [SAMPLE_BITS-1:0] typed_out);
      filt_out_t want;
      logic signed [SAMPLE_BITS-1:0] y;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid     <= 1;
      req_sample_in <= x;
      req_block_end <= be;
      do @(posedge clock); while (req_stall);
      ladder_step(x, y);
      want.sample    = typed ? typed_out : y;
      want.block_end = be;
      pending_out.push_back(want);
   endtask

   function automatic logic [WDATA_BITS-1:0] pick_value(int unsigned hi);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return WDATA_BITS'(hi);
         default: return WDATA_BITS'($urandom_range(0, hi));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return SAMPLE_BITS'($urandom_range(0, 255) - 128);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // directed rows: extremes, dry path, wet above one, resonance above pi, hard gains
   row_t rows[] = '{
      '{0, REG_STAGE_GAIN, 0, 16'sd0, 0, 1, 16'sd0},          // silence out of reset
      '{0, REG_STAGE_GAIN, 0, 16'sh7FFF, 1, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sh7FFF, 0, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sh8000, 0, 0, 0},
      '{0, REG_STAGE_GAIN, 0, -16'sd1, 1, 0, 0},
      '{1, REG_WET_MIX, 0, 0, 0, 0, 0},                        // fully dry
      '{0, REG_STAGE_GAIN, 0, 16'sh7FFF, 0, 1, 16'sh7FFF},
      '{0, REG_STAGE_GAIN, 0, 16'sh8000, 1, 1, 16'sh8000},
      '{0, REG_STAGE_GAIN, 0, 16'sd1, 0, 1, 16'sd1},
      '{1, REG_WET_MIX, 20'd65535, 0, 0, 0, 0},                // wet above one
      '{1, REG_STAGE_GAIN, 20'hFFFFF, 0, 0, 0, 0},
      '{1, REG_DRIVE, 20'd65535, 0, 0, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sh7FFF, 0, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sh8000, 1, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sh7FFF, 0, 0, 0},
      '{1, REG_RESONANCE, 20'd65535, 0, 0, 0, 0},              // resonance above pi
      '{0, REG_STAGE_GAIN, 0, 16'sh4000, 0, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sd0, 0, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sd0, 1, 0, 0},
      '{1, REG_STAGE_GAIN, 0, 0, 0, 0, 0},                     // frozen ladder
      '{1, REG_DRIVE, 0, 0, 0, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sh7FFF, 0, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sh8000, 1, 0, 0},
      '{1, REG_WET_MIX, 20'd32768, 0, 0, 0, 0},
      '{0, REG_STAGE_GAIN, 0, 16'sh1234, 0, 0, 0}
   };

   initial begin
      fill_lut();
      for (int k = 0; k < 4; k++) begin
         volt[k]  = 0;
         slope[k] = 0;
         vtanh[k] = 0;
      end
      m_gain  = GAIN_RESET;
      m_res   = RESONANCE_RESET;
      m_drive = DRIVE_RESET;
      m_wet   = WET_RESET;
      @(negedge reset);
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_write) begin
            req_valid <= 0;
            drain();
            write_reg(rows[i].reg_idx, rows[i].reg_val);
         end else begin
            send_item(rows[i].sample, rows[i].block_end, rows[i].typed, rows[i].typed_out);
         end
      end

      // random phases, each with fresh settings written while idle
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         req_valid <= 0;
         drain();
         if (p == RANDOM_PHASES - 1) quiet = 1;   // final stretch: no idling
         write_reg(REG_STAGE_GAIN, pick_value(20'hFFFFF));
         write_reg(REG_RESONANCE, pick_value(65535));
         write_reg(REG_DRIVE, pick_value(65535));
         write_reg(REG_WET_MIX, pick_value(65535));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // receiver backs off while items keep coming so the input stalls
            if (p == 2 && n == 20) hold_left = LONG_HOLD;
            send_item(pick_sample(), 1'($urandom_range(0, 1)), 0, 0);
         end
      end

      req_valid <= 0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
